[rtl/assert_macros.svh]
// Assertion macros shared by the pulse width learner RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: assertion failed");
// expr must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[rtl/irpwl_pkg.sv]
// Shared types and constants for the IR pulse width learner.
// No dependencies.
package irpwl_pkg;

    localparam int CNT_W    = 10;
    localparam int WIDTH_W  = 16;
    localparam int STAT_W   = 3;
    localparam int OP_W     = 2;
    localparam int RIDX_W   = 9;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;

    // request opcodes
    localparam logic [OP_W-1:0] OP_EDGE  = 2'd0;
    localparam logic [OP_W-1:0] OP_OVF   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // frame status codes
    localparam logic [STAT_W-1:0] ST_NONE     = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNLEARN  = 3'd1;
    localparam logic [STAT_W-1:0] ST_ACCEPT   = 3'd2;
    localparam logic [STAT_W-1:0] ST_REJECT   = 3'd3;
    localparam logic [STAT_W-1:0] ST_DISCARD  = 3'd4;

    // register index (paddr[2])
    localparam logic REG_MIN_EDGES = 1'b0;
    localparam logic REG_MAX_EDGES = 1'b1;

    localparam logic [CNT_W-1:0] MIN_EDGES_RST = 10'd30;
    localparam logic [CNT_W-1:0] MAX_EDGES_RST = 10'd280;

    // controller -> datapath commands
    typedef struct packed {
        logic exec;      // apply accepted request to frame state
        logic load_out;  // load result register (non-read ops)
        logic load_rd;   // load result register from memory read data
    } t_cmd;

endpackage

[rtl/ir_pulse_width_learner.sv]
// Top level of the IR pulse width learner: APB register file, controller, datapath.
// Depends on irpwl_pkg, irpwl_ctrl and irpwl_dp.

// IR pulse width learner. Each request is one event: op 0 reports an IR edge with
// its width in timer ticks, op 1 a capture timer overflow, op 2 reads back one
// stored width, op 3 does nothing. Every request gives exactly one result carrying
// the frame status, the running edge count, the last learned frame length, the
// polarity of the next expected edge and (for reads) the stored width.
// Edges are counted up to 1023 and flip the expected polarity; in learn mode the
// width goes to the next slot of a STORE_DEPTH-entry memory, and edges past the
// end of the memory are counted but not stored. Two overflows with no edge in
// between end the frame; in learn mode its length is kept and checked against
// the min/max edge registers (status 2 accepted, 3 rejected), otherwise status 1.
// Timing: edge, overflow and unused requests load their result on acceptance, so
// one can be accepted every cycle while results are taken; a read adds a memory wait
// state, as the width memory has a registered read port, and loads its result there.
// A new request is accepted while the previous result is being taken.
// The width memory has no reset and needs no clearing pass: a slot not yet
// written since reset returns an arbitrary value.
// Registers (APB, byte address): 0x0 min_frame_edges (reset 30),
// 0x4 max_frame_edges (reset 280), low 10 bits used; write only while idle.
module ir_pulse_width_learner #(
    parameter int STORE_DEPTH = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [irpwl_pkg::APB_AW-1:0]  paddr,
    input  logic [irpwl_pkg::APB_DW-1:0]  pwdata,
    output logic [irpwl_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [irpwl_pkg::OP_W-1:0]    i_op,
    input  logic [irpwl_pkg::WIDTH_W-1:0] i_pulse_width,
    input  logic                          i_learn_mode,
    input  logic [irpwl_pkg::RIDX_W-1:0]  i_read_index,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [irpwl_pkg::STAT_W-1:0]  o_frame_status,
    output logic [irpwl_pkg::CNT_W-1:0]   o_edge_total,
    output logic [irpwl_pkg::CNT_W-1:0]   o_learned_edges,
    output logic                          o_expect_rising,
    output logic [irpwl_pkg::WIDTH_W-1:0] o_read_width
);

    logic [irpwl_pkg::CNT_W-1:0] r_min_edges;
    logic [irpwl_pkg::CNT_W-1:0] r_max_edges;
    logic                        apb_wr;
    logic                        reg_sel;
    irpwl_pkg::t_cmd             cmd;

    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // register writes: only the low 10 bits are kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_edges <= irpwl_pkg::MIN_EDGES_RST;
            r_max_edges <= irpwl_pkg::MAX_EDGES_RST;
        end else if (apb_wr) begin
            unique case (reg_sel)
                irpwl_pkg::REG_MIN_EDGES: r_min_edges <= pwdata[irpwl_pkg::CNT_W-1:0];
                irpwl_pkg::REG_MAX_EDGES: r_max_edges <= pwdata[irpwl_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            irpwl_pkg::REG_MIN_EDGES: prdata[irpwl_pkg::CNT_W-1:0] = r_min_edges;
            irpwl_pkg::REG_MAX_EDGES: prdata[irpwl_pkg::CNT_W-1:0] = r_max_edges;
            default: prdata = '0;
        endcase
    end

    irpwl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    irpwl_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_op            (i_op),
        .i_pulse_width   (i_pulse_width),
        .i_learn_mode    (i_learn_mode),
        .i_read_index    (i_read_index),
        .i_min_edges     (r_min_edges),
        .i_max_edges     (r_max_edges),
        .o_frame_status  (o_frame_status),
        .o_edge_total    (o_edge_total),
        .o_learned_edges (o_learned_edges),
        .o_expect_rising (o_expect_rising),
        .o_read_width    (o_read_width)
    );

endmodule

[rtl/irpwl_ctrl.sv]
// Handshake controller for the IR pulse width learner.
// Depends on irpwl_pkg and assert_macros.svh.
`include "assert_macros.svh"
module irpwl_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [irpwl_pkg::OP_W-1:0] i_op,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output irpwl_pkg::t_cmd            o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RD   = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic accept;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.exec     = accept;
        o_cmd.load_out = accept && (i_op != irpwl_pkg::OP_READ);
        o_cmd.load_rd  = (r_state == S_RD);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_op == irpwl_pkg::OP_READ)) n_state = S_RD;
            end
            S_RD: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out || o_cmd.load_rd) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // result slot is always empty while waiting on memory data
    `ASSERT_NEVER(a_rd_slot_free, i_clk, i_rst_n, (r_state == S_RD) && r_out_valid)
    // a read request goes to the memory wait state next
    `ASSERT_PROP(a_rd_follows, i_clk, i_rst_n,
        accept && (i_op == irpwl_pkg::OP_READ) |=> (r_state == S_RD))
    // never two result loads at once
    `ASSERT_NEVER(a_one_load, i_clk, i_rst_n, o_cmd.load_out && o_cmd.load_rd)

endmodule

[rtl/irpwl_dp.sv]
// Datapath of the IR pulse width learner: frame state, width memory, result regs.
// Depends on irpwl_pkg and assert_macros.svh.
`include "assert_macros.svh"
module irpwl_dp #(
    parameter int STORE_DEPTH = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  irpwl_pkg::t_cmd               i_cmd,
    input  logic [irpwl_pkg::OP_W-1:0]    i_op,
    input  logic [irpwl_pkg::WIDTH_W-1:0] i_pulse_width,
    input  logic                          i_learn_mode,
    input  logic [irpwl_pkg::RIDX_W-1:0]  i_read_index,
    input  logic [irpwl_pkg::CNT_W-1:0]   i_min_edges,
    input  logic [irpwl_pkg::CNT_W-1:0]   i_max_edges,
    output logic [irpwl_pkg::STAT_W-1:0]  o_frame_status,
    output logic [irpwl_pkg::CNT_W-1:0]   o_edge_total,
    output logic [irpwl_pkg::CNT_W-1:0]   o_learned_edges,
    output logic                          o_expect_rising,
    output logic [irpwl_pkg::WIDTH_W-1:0] o_read_width
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam logic [irpwl_pkg::CNT_W-1:0] DEPTH_C = irpwl_pkg::CNT_W'(STORE_DEPTH);

    logic [irpwl_pkg::WIDTH_W-1:0] mem [STORE_DEPTH];

    logic [irpwl_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [irpwl_pkg::CNT_W-1:0]   r_cao, n_cao;
    logic                          r_pend, n_pend;
    logic                          r_rise, n_rise;
    logic [irpwl_pkg::CNT_W-1:0]   r_kept, n_kept;
    logic [irpwl_pkg::STAT_W-1:0]  n_status;
    logic [irpwl_pkg::STAT_W-1:0]  r_frame_status;
    logic [irpwl_pkg::WIDTH_W-1:0] r_read_width;
    logic [irpwl_pkg::WIDTH_W-1:0] r_rd_data;
    logic                          r_rd_ok;
    logic                          mem_we;
    logic                          rd_en;
    logic                          rd_in_range;
    logic [irpwl_pkg::CNT_W-1:0]   ridx_ext;

    assign ridx_ext    = {1'b0, i_read_index};
    assign rd_in_range = ridx_ext < DEPTH_C;
    assign rd_en       = i_cmd.exec && (i_op == irpwl_pkg::OP_READ);

    always_comb begin
        n_cnt    = r_cnt;
        n_cao    = r_cao;
        n_pend   = r_pend;
        n_rise   = r_rise;
        n_kept   = r_kept;
        n_status = irpwl_pkg::ST_NONE;
        mem_we   = 1'b0;
        if (i_cmd.exec) begin
            unique case (i_op)
                irpwl_pkg::OP_EDGE: begin
                    n_pend = 1'b0;
                    mem_we = i_learn_mode && (r_cnt < DEPTH_C);
                    if (r_cnt != irpwl_pkg::CNT_MAX) n_cnt = r_cnt + 1'b1;
                    n_rise = ~r_rise;
                end
                irpwl_pkg::OP_OVF: begin
                    if (r_cnt != '0) begin
                        if (r_pend) begin
                            if (r_cnt == r_cao) begin
                                if (i_learn_mode) begin
                                    n_kept = r_cao;
                                    if ((r_cao <= i_max_edges) && (r_cao >= i_min_edges))
                                        n_status = irpwl_pkg::ST_ACCEPT;
                                    else
                                        n_status = irpwl_pkg::ST_REJECT;
                                end else begin
                                    n_status = irpwl_pkg::ST_UNLEARN;
                                end
                            end else begin
                                n_status = irpwl_pkg::ST_DISCARD;
                            end
                            // frame ends
                            n_cnt  = '0;
                            n_cao  = '0;
                            n_pend = 1'b0;
                            n_rise = 1'b0;
                        end else begin
                            n_cao  = r_cnt;
                            n_pend = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_cao  <= '0;
            r_pend <= 1'b0;
            r_rise <= 1'b0;
            r_kept <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_cao  <= n_cao;
            r_pend <= n_pend;
            r_rise <= n_rise;
            r_kept <= n_kept;
        end
    end

    // width memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_cnt[AW-1:0]] <= i_pulse_width;
        end
        if (rd_en && rd_in_range) begin
            r_rd_data <= mem[ridx_ext[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_ok <= rd_in_range;
        end
        if (i_cmd.load_out) begin
            r_frame_status <= n_status;
            r_read_width   <= '0;
        end else if (i_cmd.load_rd) begin
            r_frame_status <= irpwl_pkg::ST_NONE;
            r_read_width   <= r_rd_ok ? r_rd_data : '0;
        end
    end

    assign o_frame_status  = r_frame_status;
    assign o_edge_total    = r_cnt;
    assign o_learned_edges = r_kept;
    assign o_expect_rising = r_rise;
    assign o_read_width    = r_read_width;

    // a pending overflow always holds the live, nonzero count
    `ASSERT_PROP(a_pend_count, i_clk, i_rst_n,
        r_pend |-> ((r_cao == r_cnt) && (r_cnt != '0)))
    // saturated counter stays put or is cleared by a frame end
    `ASSERT_PROP(a_cnt_sat, i_clk, i_rst_n,
        (r_cnt == irpwl_pkg::CNT_MAX) |=> ((r_cnt == irpwl_pkg::CNT_MAX) || (r_cnt == '0)))
    // frame state only moves on an accepted request
    `ASSERT_PROP(a_state_hold, i_clk, i_rst_n,
        !i_cmd.exec |=> ($stable(r_cnt) && $stable(r_rise) && $stable(r_kept)))

endmodule
